// ----- rtl/core/line_follow_pd_steer_assert.svh -----
// Assertion macros for the line follower steering block.
`ifndef LINE_FOLLOW_PD_STEER_ASSERT_SVH
`define LINE_FOLLOW_PD_STEER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LFPS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LFPS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/lfps_pkg.sv -----
// Constants and types shared by the line follower steering block.
`timescale 1ns / 1ps

package lfps_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_THRESH = 2'd0,
    CFG_HOLD   = 2'd1,
    CFG_LIMIT  = 2'd2
  } cfg_idx_t;

  localparam logic [9:0] THRESH_RST = 10'd800;
  localparam logic [3:0] HOLD_RST   = 4'd10;
  localparam logic [9:0] LIMIT_RST  = 10'd1000;

  localparam int NUM_SENSORS = 6;
  localparam int SAMPLE_W    = 10;
  localparam int ERR_W       = 5;
  localparam int DRIVE_W     = 14;

  // Sensor weights by lit count; row zero serves none, five or six lit.
  localparam logic signed [ERR_W-1:0] WEIGHT_TAB [5][6] = '{
    '{5'sd0, 5'sd0, 5'sd0,  5'sd0,  5'sd0,  5'sd0},
    '{5'sd9, 5'sd3, 5'sd1, -5'sd1, -5'sd3, -5'sd9},
    '{5'sd3, 5'sd3, 5'sd0,  5'sd0, -5'sd3, -5'sd3},
    '{5'sd2, 5'sd2, 5'sd0,  5'sd0, -5'sd2, -5'sd2},
    '{5'sd2, 5'sd0, 5'sd0,  5'sd0,  5'sd0, -5'sd2}
  };

  // Gain bands on the window sum magnitude.
  localparam int BAND_LO  = 30;
  localparam int BAND_MID = 80;
  localparam int BAND_HI  = 120;

  localparam logic [9:0] KP_LO   = 10'd30;
  localparam logic [9:0] KP_MID  = 10'd120;
  localparam logic [9:0] KP_HI   = 10'd300;
  localparam logic [9:0] KP_TOP  = 10'd500;
  localparam logic [6:0] KD_LO   = 7'd10;
  localparam logic [6:0] KD_MID  = 7'd40;
  localparam logic [6:0] KD_HI   = 7'd70;
  localparam logic [6:0] KD_TOP  = 7'd90;

endpackage

// ----- rtl/core/line_follow_pd_steer.sv -----
// Line follower PD steering controller: sensors in, motor duties out.
`timescale 1ns / 1ps
`include "line_follow_pd_steer_assert.svh"

// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid/s_tready    six 10-bit sensor samples
// m_*       out        m_tvalid/m_tready    duties, line error, pattern; no_line in tuser
// cfg_*     in         cfg_valid/cfg_ready  register index and write data
//
// One item per cycle sustained while m_tready stays high; each result passes
// all five register stages: input, threshold/weighting, window update, gains and
// products, clamp and split. The window update is the only loop.
// Each stage holds on its own when the next is full, so bubbles close up.
// The error history needs no clearing pass after reset: a fill flag marks the
// first full turn of the pointer, and entries not yet written read as zero.
module line_follow_pd_steer
  import lfps_pkg::*;
#(
  parameter int WINDOW = 300
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // sample_far_right, sample_mid_right, sample_near_right, sample_near_left,
  // sample_mid_left, sample_far_left (10 bits each), 4 pad bits
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // right_duty[9:0], left_duty[19:10], line_error[24:20], sensor_pattern[30:25], pad
  output logic [31:0] m_tdata,
  // no_line[0]
  output logic [0:0]  m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  localparam int PTR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_RAW = $clog2(9 * WINDOW + 1) + 1;
  localparam int SUM_W   = (SUM_RAW > 9) ? SUM_RAW : 9;
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(9 * WINDOW);

  // Configuration registers.
  logic [9:0] sensor_threshold;
  logic [3:0] hold_period;
  logic [9:0] duty_limit;

  // Stage valids and free flags.
  logic v1, v2, v3, v4;
  logic free1, free2, free3, free4, free5;

  // Stage 1: samples.
  logic [NUM_SENSORS*SAMPLE_W-1:0] samples1;

  // Stage 2: error, pattern, no-line flag.
  logic signed [ERR_W-1:0] err2;
  logic [5:0]              pat2;
  logic                    nl2;
  logic signed [ERR_W-1:0] err2_next;
  logic [5:0]              pat2_next;
  logic                    nl2_next;

  // Window state.
  logic signed [ERR_W-1:0] hist_mem [WINDOW];
  logic signed [ERR_W-1:0] hist_rd;
  logic signed [ERR_W-1:0] byp_data;
  logic                    byp;
  logic [PTR_W-1:0]        ptr;
  logic [PTR_W-1:0]        ptr_inc;
  logic [PTR_W-1:0]        raddr;
  logic                    full;
  logic                    wrap;
  logic signed [SUM_W-1:0] window_sum;
  logic signed [SUM_W-1:0] window_sum_next;
  logic signed [ERR_W-1:0] oldest;
  logic signed [ERR_W-1:0] held_error;
  logic [3:0]              hold_count;
  logic [3:0]              hold_inc;
  logic                    update;

  // Stage 3: updated sum, error, held error before this item.
  logic signed [SUM_W-1:0] sum3;
  logic signed [ERR_W-1:0] err3;
  logic signed [ERR_W-1:0] hd3;
  logic [5:0]              pat3;
  logic                    nl3;

  // Stage 4: P and D products.
  logic [SUM_W-1:0]          mag3;
  logic [9:0]                kp3;
  logic [6:0]                kd3;
  logic signed [ERR_W:0]     derr3;
  logic signed [DRIVE_W-1:0] pprod3;
  logic signed [DRIVE_W-1:0] dprod3;
  logic signed [DRIVE_W-1:0] p4;
  logic signed [DRIVE_W-1:0] d4;
  logic signed [ERR_W-1:0]   err4;
  logic [5:0]                pat4;
  logic                      nl4;

  // Stage 5: clamp and split, output register.
  logic signed [DRIVE_W-1:0] drive;
  logic signed [DRIVE_W-1:0] lim_s;
  logic signed [DRIVE_W-1:0] drive_c;
  logic signed [DRIVE_W-1:0] right_w;
  logic signed [DRIVE_W-1:0] left_w;
  logic [9:0]                right_duty;
  logic [9:0]                left_duty;
  logic signed [ERR_W-1:0]   err5;
  logic [5:0]                pat5;
  logic                      nl5;

  // Let a stage load when it is empty or its content moves on.
  assign free5    = !m_tvalid || m_tready;
  assign free4    = !v4 || free5;
  assign free3    = !v3 || free4;
  assign free2    = !v2 || free3;
  assign free1    = !v1 || free2;
  assign s_tready = free1;
  assign cfg_ready = 1'b1;

  // Take configuration writes; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_threshold <= THRESH_RST;
      hold_period      <= HOLD_RST;
      duty_limit       <= LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THRESH: sensor_threshold <= cfg_data;
        CFG_HOLD:   hold_period      <= cfg_data[3:0];
        CFG_LIMIT:  duty_limit       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (free1) v1 <= s_tvalid;
      if (free2) v2 <= v1;
      if (free3) v3 <= v2;
      if (free4) v4 <= v3;
      if (free5) m_tvalid <= v4;
    end
  end

  // Stage 1: hold the raw samples.
  always_ff @(posedge clk) begin
    if (free1) samples1 <= s_tdata[NUM_SENSORS*SAMPLE_W-1:0];
  end

  // Threshold each sample, count the lit ones and weight them.
  always_comb begin
    logic [2:0]          cnt;
    logic [2:0]          row;
    logic [5:0]          lit;
    logic [SAMPLE_W-1:0] smp;
    cnt = 3'd0;
    lit = 6'd0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      smp    = samples1[i*SAMPLE_W +: SAMPLE_W];
      lit[i] = (smp > sensor_threshold);
      cnt    = cnt + {2'b00, lit[i]};
    end
    // Five or six lit fall back to the all-zero row.
    row = (cnt <= 3'd4) ? cnt : 3'd0;
    err2_next = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (lit[i]) err2_next = err2_next + WEIGHT_TAB[row][i];
    end
    for (int i = 0; i < NUM_SENSORS; i++) begin
      pat2_next[NUM_SENSORS-1-i] = lit[i];
    end
    nl2_next = (cnt == 3'd0);
  end

  always_ff @(posedge clk) begin
    if (free2) begin
      err2 <= err2_next;
      pat2 <= pat2_next;
      nl2  <= nl2_next;
    end
  end

  // Window update: drop the oldest error, insert the newest.
  assign update  = free3 && v2;
  assign wrap    = (ptr == PTR_W'(WINDOW - 1));
  assign ptr_inc = wrap ? '0 : ptr + 1'b1;
  assign raddr   = update ? ptr_inc : ptr;
  // An entry not yet written since reset reads as zero.
  assign oldest  = !full ? '0 : (byp ? byp_data : hist_rd);
  assign window_sum_next = window_sum + SUM_W'(err2) - SUM_W'(oldest);
  assign hold_inc = hold_count + 4'd1;

  // History memory: one write, one registered read, a forward for a one-entry window.
  always_ff @(posedge clk) begin
    if (update) hist_mem[ptr] <= err2;
    hist_rd  <= hist_mem[raddr];
    byp      <= update && (raddr == ptr);
    byp_data <= err2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      full       <= 1'b0;
      window_sum <= '0;
      held_error <= '0;
      hold_count <= 4'd0;
    end else if (update) begin
      ptr        <= ptr_inc;
      if (wrap) full <= 1'b1;
      window_sum <= window_sum_next;
      // Latch the error for the D term once every hold period.
      if (hold_inc == hold_period) begin
        held_error <= err2;
        hold_count <= 4'd0;
      end else begin
        hold_count <= hold_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free3) begin
      sum3 <= window_sum_next;
      err3 <= err2;
      hd3  <= held_error;
      pat3 <= pat2;
      nl3  <= nl2;
    end
  end

  // Pick gains from the sum magnitude and form the products.
  always_comb begin
    mag3 = sum3[SUM_W-1] ? SUM_W'(-sum3) : SUM_W'(sum3);
    if (mag3 < SUM_W'(BAND_LO)) begin
      kp3 = KP_LO;
      kd3 = KD_LO;
    end else if (mag3 < SUM_W'(BAND_MID)) begin
      kp3 = KP_MID;
      kd3 = KD_MID;
    end else if (mag3 < SUM_W'(BAND_HI)) begin
      kp3 = KP_HI;
      kd3 = KD_HI;
    end else begin
      kp3 = KP_TOP;
      kd3 = KD_TOP;
    end
    derr3  = {err3[ERR_W-1], err3} - {hd3[ERR_W-1], hd3};
    pprod3 = $signed({4'd0, kp3}) * DRIVE_W'(err3);
    dprod3 = $signed({7'd0, kd3}) * DRIVE_W'(derr3);
  end

  always_ff @(posedge clk) begin
    if (free4) begin
      p4   <= pprod3;
      d4   <= dprod3;
      err4 <= err3;
      pat4 <= pat3;
      nl4  <= nl3;
    end
  end

  // Sum, clamp to the duty limit and split across the motors.
  always_comb begin
    drive = p4 + d4;
    lim_s = $signed({{(DRIVE_W-10){1'b0}}, duty_limit});
    if (drive > lim_s) begin
      drive_c = lim_s;
    end else if (drive < -lim_s) begin
      drive_c = -lim_s;
    end else begin
      drive_c = drive;
    end
    if (!drive_c[DRIVE_W-1]) begin
      right_w = lim_s;
      left_w  = lim_s - drive_c;
    end else begin
      right_w = lim_s + drive_c;
      left_w  = lim_s;
    end
  end

  always_ff @(posedge clk) begin
    if (free5) begin
      right_duty <= right_w[9:0];
      left_duty  <= left_w[9:0];
      err5       <= err4;
      pat5       <= pat4;
      nl5        <= nl4;
    end
  end

  assign m_tdata = {1'b0, pat5, err5, left_duty, right_duty};
  assign m_tuser = nl5;

  // Checks on the window logic and the result fields.
  `LFPS_ASSERT_IMP(a_ptr_range, 1'b1, ptr <= PTR_W'(WINDOW - 1), "history pointer out of range")
  `LFPS_ASSERT_IMP(a_sum_hi, !window_sum[SUM_W-1], window_sum <= SUM_MAX, "sum above bound")
  `LFPS_ASSERT_IMP(a_sum_lo, window_sum[SUM_W-1], window_sum >= -SUM_MAX, "sum below bound")
  `LFPS_ASSERT_IMP(a_nl_err, m_tvalid && m_tuser[0], m_tdata[24:20] == 5'd0, "no-line error")
  `LFPS_ASSERT_NXT(a_update_kept, update, v3, "updated item lost after the window stage")

endmodule

// ----- dv/line_follow_pd_steer_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the line follower PD steering block.
module line_follow_pd_steer_tb;
  import lfps_pkg::*;

  localparam int HIST_DEPTH = 300;  // error history length, kept equal to the DUT's WINDOW
  localparam int SEG_ITEMS  = 82;   // items per random segment
  localparam int NUM_SEGS   = 6;

  // Error weight of each sensor (0 = far right .. 5 = far left), by lit count.
  // Row zero stands for no sensor lit; five or six lit also give zero error.
  localparam int ERR_WEIGHT [5][6] = '{
    '{0, 0, 0,  0,  0,  0},
    '{9, 3, 1, -1, -3, -9},
    '{3, 3, 0,  0, -3, -3},
    '{2, 2, 0,  0, -2, -2},
    '{2, 0, 0,  0,  0, -2}
  };

  // One expected result item.
  typedef struct {
    logic [9:0]        right_duty;
    logic [9:0]        left_duty;
    logic signed [4:0] line_error;
    logic [5:0]        pattern;
    logic              no_line;
  } steer_result_t;

  // Steering predictor plus the queue of duties still owed by the DUT.
  class duty_scoreboard;
    logic [9:0]    threshold;
    logic [3:0]    hold_period;
    logic [9:0]    limit;
    int            err_hist [HIST_DEPTH];
    int            hist_ptr;
    int            window_sum;
    int            held_err;
    logic [3:0]    hold_cnt;
    steer_result_t expected_duties [$];
    int            mismatches;

    function new();
      threshold   = 10'd800;
      hold_period = 4'd10;
      limit       = 10'd1000;
      foreach (err_hist[i]) err_hist[i] = 0;
      hist_ptr    = 0;
      window_sum  = 0;
      held_err    = 0;
      hold_cnt    = 4'd0;
      mismatches  = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [9:0] data);
      case (idx)
        CFG_THRESH: threshold = data;
        CFG_HOLD:   hold_period = data[3:0];
        CFG_LIMIT:  limit = data;
        default: ;
      endcase
    endfunction

    // Work out the duties for one accepted sample item and queue them.
    function void take_samples(logic [63:0] word);
      int            i;
      int            lit_count;
      int            err;
      int            mag;
      int            kp;
      int            kd;
      int            drive;
      int            lim;
      logic [5:0]    lit;
      logic [5:0]    pattern;
      steer_result_t r;
      lit_count = 0;
      err       = 0;
      pattern   = '0;
      for (i = 0; i < 6; i++) begin
        lit[i]       = word[10*i +: 10] > threshold;
        lit_count   += int'(lit[i]);
        pattern[5-i] = lit[i];
      end
      if (lit_count <= 4) begin
        for (i = 0; i < 6; i++) begin
          if (lit[i]) err += ERR_WEIGHT[lit_count][i];
        end
      end
      // Swap the oldest error out of the window for the newest.
      window_sum        += err - err_hist[hist_ptr];
      err_hist[hist_ptr] = err;
      hist_ptr           = (hist_ptr + 1) % HIST_DEPTH;
      mag = (window_sum < 0) ? -window_sum : window_sum;
      if (mag < 30) begin
        kp = 30;  kd = 10;
      end else if (mag < 80) begin
        kp = 120; kd = 40;
      end else if (mag < 120) begin
        kp = 300; kd = 70;
      end else begin
        kp = 500; kd = 90;
      end
      // D term sees the held error from before this step.
      drive    = kp * err + kd * (err - held_err);
      hold_cnt = hold_cnt + 4'd1;
      if (hold_cnt == hold_period) begin
        held_err = err;
        hold_cnt = 4'd0;
      end
      lim = int'(limit);
      if (drive > lim) drive = lim;
      else if (drive < -lim) drive = -lim;
      if (drive >= 0) begin
        r.right_duty = 10'(lim);
        r.left_duty  = 10'(lim - drive);
      end else begin
        r.right_duty = 10'(lim + drive);
        r.left_duty  = 10'(lim);
      end
      r.line_error = 5'(err);
      r.pattern    = pattern;
      r.no_line    = (lit_count == 0);
      expected_duties.push_back(r);
    endfunction

    // Compare one accepted result item with the oldest expectation.
    function void check_duties(logic [31:0] data, logic no_line);
      steer_result_t e;
      if (expected_duties.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t: result item %h (no_line %b) with nothing pending", $realtime, data,
                   no_line);
        return;
      end
      e = expected_duties.pop_front();
      if (data[9:0] !== e.right_duty || data[19:10] !== e.left_duty ||
          data[24:20] !== e.line_error || data[30:25] !== e.pattern ||
          no_line !== e.no_line) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t: mismatch exp R %0d L %0d err %0d pat %b nl %b, got R %0d L %0d err %0d pat %b nl %b",
                   $realtime, e.right_duty, e.left_duty, e.line_error, e.pattern, e.no_line,
                   data[9:0], data[19:10], $signed(data[24:20]), data[30:25], no_line);
      end
    endfunction
  endclass

  // Clock and DUT inputs, all known from time zero.
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic [63:0] s_tdata   = '0;
  logic        m_tready  = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [9:0]  cfg_data  = '0;
  logic        s_tready;
  logic        m_tvalid;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_ready;

  int          src_gap_pct   = 22;   // chance of the sender idling before an item
  int          snk_stall_pct = 61;   // chance of the receiver stalling in a cycle
  logic [9:0]  cur_thresh    = 10'd800;

  duty_scoreboard duty_sb = new();

  line_follow_pd_steer #(
    .WINDOW(HIST_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: stall at random with the current stall rate; hold ready low in reset.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Monitor: sample every handshake at the edge and feed the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) duty_sb.write_reg(cfg_idx_t'(cfg_index), cfg_data);
      if (s_tvalid && s_tready) duty_sb.take_samples(s_tdata);
      if (m_tvalid && m_tready) duty_sb.check_duties(m_tdata, m_tuser[0]);
    end
  end

  // Build a sample item whose lit sensors follow lit_mask (bit i = sensor i).
  function automatic logic [63:0] sample_word(input logic [5:0] lit_mask,
                                              input logic [9:0] thr);
    logic [63:0] word;
    int          i;
    word = '0;
    for (i = 0; i < 6; i++) begin
      if (lit_mask[i] && thr != 10'h3FF) begin
        word[10*i +: 10] = 10'($urandom_range(1023, int'(thr) + 1));
      end else begin
        word[10*i +: 10] = 10'($urandom_range(int'(thr), 0));
      end
    end
    return word;
  endfunction

  // Fully random samples: the noise part of the stimulus.
  function automatic logic [63:0] noise_word();
    logic [63:0] word;
    int          i;
    word = '0;
    for (i = 0; i < 6; i++) word[10*i +: 10] = 10'($urandom_range(1023, 0));
    return word;
  endfunction

  // Offer one item, after a random gap, and return at the edge that takes it.
  // Leave valid high so back-to-back items need no second assignment.
  task automatic send_item(input logic [63:0] word);
    if ($urandom_range(99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_gap_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Drop valid and hold off until every expected result has come, then let the
  // pipeline settle.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (duty_sb.expected_duties.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Write all three registers back to back; only called with the DUT idle.
  task automatic write_settings(input logic [9:0] thr, input logic [3:0] hold,
                                input logic [9:0] lim);
    cfg_idx_t   idx [3];
    logic [9:0] val [3];
    int         k;
    idx = '{CFG_THRESH, CFG_HOLD, CFG_LIMIT};
    val = '{thr, {6'd0, hold}, lim};
    for (k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid  <= 1'b0;
    cur_thresh  = thr;
  endtask

  initial begin
    int         seg;
    int         half;
    int         n;
    int         k;
    int         run_len;
    int         w;
    bit         noisy;
    logic [5:0] lit_mask;
    logic [3:0] hold;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset settings: no line, all lit, the threshold edge
    // (equal is dark, one above is lit), each lone sensor, and every lit count.
    send_item(64'd0);
    send_item({4'd0, {6{10'h3FF}}});
    send_item({4'd0, {5{10'd800}}, 10'd801});
    for (k = 0; k < 6; k++) send_item(sample_word(6'd1 << k, cur_thresh));
    send_item(sample_word(6'b000011, cur_thresh));
    send_item(sample_word(6'b110000, cur_thresh));
    send_item(sample_word(6'b000111, cur_thresh));
    send_item(sample_word(6'b111000, cur_thresh));
    send_item(sample_word(6'b001111, cur_thresh));
    send_item(sample_word(6'b111100, cur_thresh));
    send_item(sample_word(6'b011111, cur_thresh));
    drain_results();

    // Low extremes: zero threshold, shortest hold, zero duty.
    write_settings(10'd0, 4'd1, 10'd0);
    send_item(64'd0);
    send_item({4'd0, {6{10'd1}}});
    send_item(sample_word(6'b000001, cur_thresh));
    drain_results();

    // High extremes: nothing can exceed the top threshold.
    write_settings(10'h3FF, 4'd15, 10'h3FF);
    send_item({4'd0, {6{10'h3FF}}});
    send_item(noise_word());
    drain_results();

    // Random segments. Hold the line in one place for runs of items so the
    // window sum climbs through every gain band; mix in short noise bursts.
    // Alternate long and short hold periods so the period often drops below
    // the running count.
    n = 0;
    for (seg = 0; seg < NUM_SEGS; seg++) begin
      case (seg / 2)
        0: begin
          src_gap_pct = 22; snk_stall_pct = 61;
        end
        1: begin
          src_gap_pct = 61; snk_stall_pct = 22;
        end
        default: begin
          src_gap_pct = 0;  snk_stall_pct = 0;
        end
      endcase
      hold = (seg % 2 == 0) ? 4'($urandom_range(15, 8)) : 4'($urandom_range(4, 1));
      write_settings(10'($urandom_range(900, 100)), hold, 10'($urandom_range(1023, 0)));
      n = 0;
      // Pause at mid-segment until all results are back, and again at the end.
      for (half = 1; half <= 2; half++) begin
        while (n < SEG_ITEMS * half / 2) begin
          noisy = ($urandom_range(99) < 20);
          if (noisy) begin
            run_len  = $urandom_range(5, 1);
            lit_mask = '0;
          end else begin
            run_len = $urandom_range(40, 4);
            if ($urandom_range(99) < 75) begin
              w        = $urandom_range(3, 1);
              lit_mask = 6'(((1 << w) - 1) << $urandom_range(6 - w, 0));
            end else begin
              lit_mask = 6'($urandom_range(63, 0));
            end
          end
          for (k = 0; k < run_len && n < SEG_ITEMS * half / 2; k++) begin
            send_item(noisy ? noise_word() : sample_word(lit_mask, cur_thresh));
            n++;
          end
        end
        drain_results();
      end
    end

    if (duty_sb.mismatches == 0 && duty_sb.expected_duties.size() == 0) begin
      $display("line_follow_pd_steer_tb: done, clean");
    end else begin
      $display("line_follow_pd_steer_tb: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #200_000;
    $display("line_follow_pd_steer_tb: done, errors");
    $finish;
  end

endmodule
